>>> hw/rtl/point_in_polygon_hit_test_unit_defines.svh
// Assertion macros shared by the hit test RTL.
`ifndef POINT_IN_POLYGON_HIT_TEST_UNIT_DEFINES_SVH
`define POINT_IN_POLYGON_HIT_TEST_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define PIP_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define PIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/pip_pkg.sv
// Package: sizes, state type and field offsets of the hit test unit.
package pip_pkg;

  localparam int MaxCells  = 32;
  localparam int MaxVerts  = 16;
  localparam int CellW     = $clog2(MaxCells);
  localparam int VertW     = $clog2(MaxVerts);
  localparam int AddrW     = CellW + VertW;
  localparam int Depth     = MaxCells * MaxVerts;
  localparam int CntW      = $clog2(MaxVerts + 1);
  localparam int CfgW      = 6;
  localparam int CoordW    = 16;
  localparam int DiffW     = CoordW + 1;
  localparam int ProdW     = 2 * DiffW;

  // Request tdata layout, lowest bit first
  localparam int InDataW   = 80;
  localparam int OffCell   = 0;
  localparam int OffVert   = OffCell + CellW;
  localparam int OffVx     = OffVert + VertW;
  localparam int OffVy     = OffVx + CoordW;
  localparam int OffPx     = OffVy + CoordW;
  localparam int OffPy     = OffPx + CoordW;

  // Result tdata layout
  localparam int OutDataW  = 8;

  // Request kinds carried on tuser
  localparam logic ReqWrite = 1'b0;
  localparam logic ReqQuery = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StCell,
    StLoadJ,
    StFetch,
    StMulL,
    StMulR,
    StCmp,
    StDone
  } pip_state_e;

endpackage

>>> hw/rtl/point_in_polygon_hit_test_unit.sv
// Top level: polygon vertex store and crossing-number hit test sequencer.
//
// Usage:
//   s_axis carries requests. tuser = 0 writes one vertex (cell_index,
//   vertex_index, vertex_x, vertex_y); tlast closes the polygon and sets its
//   vertex count to vertex_index + 1. tuser = 1 asks a point query.
//   m_axis returns one result per request: tuser = 1 for a query answer,
//   0 for a write acknowledge; tdata holds hit and hit_cell.
//   cfg writes cell_count, the number of polygons a query examines
//   (values above 32 act as 32). Write it only while the block is idle.
// Operation:
//   A vertex write's acknowledge is registered and shows on the next cycle.
//   A query walks polygons 0 .. cell_count-1 through one vertex memory read
//   port and one shared 17x17 multiplier. A polygon with no vertices is
//   skipped in StCell; each edge of a polygon passes StFetch, StMulL, StMulR
//   and StCmp, after StCell and StLoadJ open the polygon. The walk stops at
//   the first hit.
// Reset: vertex counts, cell_count and all control clear; vertex memory is
//   not cleared. If the receiver stalls, the result waits in the output
//   register and no new request is taken until it leaves.
module point_in_polygon_hit_test_unit
  import pip_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Request channel
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // cell_index, vertex_index, vertex_x, vertex_y, point_x, point_y, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // req_type
  input  logic                s_axis_tuser_i,
  // last_vertex
  input  logic                s_axis_tlast_i,
  // Result channel
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // hit, hit_cell, zero pad
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // is_query
  output logic                m_axis_tuser_o,
  // Configuration channel (cell_count)
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgW-1:0]     cfg_data_i
);

  `include "point_in_polygon_hit_test_unit_defines.svh"

  pip_state_e state_q, state_d;

  logic [CfgW-1:0]   cell_count_q;
  logic [CfgW-1:0]   limit_q;
  logic [CfgW-1:0]   k_q;
  logic [CntW-1:0]   i_q;
  logic [CntW-1:0]   n_q;
  logic [CntW-1:0]   i_next;
  logic [CntW-1:0]   cnt_q [MaxCells];
  logic [CntW-1:0]   cnt_cur;
  logic [CntW-1:0]   n_last;
  logic              parity_q;
  logic              parity_d;

  logic signed [CoordW-1:0] px_q, py_q, xi_q, yi_q, xj_q, yj_q;
  logic signed [ProdW-1:0]  lhs_q, rhs_q;
  logic signed [DiffW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0]  mul_p;

  logic [2*CoordW-1:0] vmem [Depth];
  logic [2*CoordW-1:0] rdata_q;
  logic                rd_en;
  logic [AddrW-1:0]    rd_addr;

  logic out_valid_q, out_query_q, out_hit_q;
  logic [CellW-1:0] out_cell_q;
  logic out_free;
  logic s_acc;
  logic wr_req;
  logic cell_over;
  logic cell_empty;
  logic last_edge;
  logic straddle;
  logic right_of;

  logic [CellW-1:0]  in_cell;
  logic [VertW-1:0]  in_vert;
  logic [CoordW-1:0] in_vx, in_vy, in_px, in_py;

  // Request field unpacking
  assign in_cell = s_axis_tdata_i[OffCell +: CellW];
  assign in_vert = s_axis_tdata_i[OffVert +: VertW];
  assign in_vx   = s_axis_tdata_i[OffVx +: CoordW];
  assign in_vy   = s_axis_tdata_i[OffVy +: CoordW];
  assign in_px   = s_axis_tdata_i[OffPx +: CoordW];
  assign in_py   = s_axis_tdata_i[OffPy +: CoordW];

  // Handshakes
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == StIdle) && out_free;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign wr_req          = s_acc && (s_axis_tuser_i == ReqWrite);
  assign cfg_ready_o     = 1'b1;

  // Walk status
  assign cnt_cur    = cnt_q[k_q[CellW-1:0]];
  assign n_last     = cnt_cur - CntW'(1);
  assign cell_over  = (k_q >= limit_q);
  assign cell_empty = (cnt_cur == '0);
  assign i_next     = i_q + CntW'(1);
  assign last_edge  = (i_next == n_q);

  // Edge tests: straddle on y, side by cross-multiplication
  assign straddle = ((yi_q <= py_q) && (py_q < yj_q)) || ((yj_q <= py_q) && (py_q < yi_q));
  assign right_of = (yj_q > yi_q) ? (lhs_q > rhs_q) : (lhs_q < rhs_q);
  assign parity_d = parity_q ^ (straddle && right_of);

  // Shared multiplier, operands chosen by step
  always_comb begin
    if (state_q == StMulL) begin
      mul_a = DiffW'(px_q) - DiffW'(xi_q);
      mul_b = DiffW'(yj_q) - DiffW'(yi_q);
    end else begin
      mul_a = DiffW'(xj_q) - DiffW'(xi_q);
      mul_b = DiffW'(py_q) - DiffW'(yi_q);
    end
  end
  assign mul_p = mul_a * mul_b;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (s_acc && (s_axis_tuser_i == ReqQuery)) state_d = StCell;
      end
      StCell: begin
        if (cell_over) state_d = StDone;
        else if (!cell_empty) state_d = StLoadJ;
      end
      StLoadJ: state_d = StFetch;
      StFetch: state_d = StMulL;
      StMulL:  state_d = StMulR;
      StMulR:  state_d = StCmp;
      StCmp: begin
        if (!last_edge) state_d = StFetch;
        else if (parity_d) state_d = StDone;
        else state_d = StCell;
      end
      StDone: begin
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Memory read requests
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state_q)
      StCell: begin
        rd_en   = !cell_over && !cell_empty;
        rd_addr = {k_q[CellW-1:0], n_last[VertW-1:0]};
      end
      StLoadJ: begin
        rd_en   = 1'b1;
        rd_addr = {k_q[CellW-1:0], VertW'(0)};
      end
      StCmp: begin
        rd_en   = !last_edge;
        rd_addr = {k_q[CellW-1:0], i_next[VertW-1:0]};
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = '0;
      end
    endcase
  end

  // Vertex memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_req) vmem[{in_cell, in_vert}] <= {in_vy, in_vx};
    if (rd_en) rdata_q <= vmem[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cell_count_q <= '0;
      limit_q      <= '0;
      k_q          <= '0;
      i_q          <= '0;
      n_q          <= '0;
      parity_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int c = 0; c < MaxCells; c++) cnt_q[c] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) cell_count_q <= cfg_data_i;
      if (wr_req && s_axis_tlast_i) cnt_q[in_cell] <= CntW'(in_vert) + CntW'(1);
      case (state_q)
        StIdle: begin
          if (s_acc && (s_axis_tuser_i == ReqQuery)) begin
            k_q     <= '0;
            limit_q <= (cell_count_q > CfgW'(MaxCells)) ? CfgW'(MaxCells) : cell_count_q;
          end
        end
        StCell: begin
          if (!cell_over) begin
            if (cell_empty) k_q <= k_q + CfgW'(1);
            else n_q <= cnt_cur;
          end
        end
        StLoadJ: begin
          i_q      <= '0;
          parity_q <= 1'b0;
        end
        StCmp: begin
          parity_q <= parity_d;
          if (!last_edge) i_q <= i_next;
          else if (!parity_d) k_q <= k_q + CfgW'(1);
        end
        default: ;
      endcase
      // Result register
      if (wr_req) out_valid_q <= 1'b1;
      else if (state_q == StDone && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath and result payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        px_q <= in_px;
        py_q <= in_py;
      end
      StLoadJ: begin
        xj_q <= rdata_q[CoordW-1:0];
        yj_q <= rdata_q[2*CoordW-1:CoordW];
      end
      StFetch: begin
        xi_q <= rdata_q[CoordW-1:0];
        yi_q <= rdata_q[2*CoordW-1:CoordW];
      end
      StMulL: lhs_q <= mul_p;
      StMulR: rhs_q <= mul_p;
      StCmp: begin
        xj_q <= xi_q;
        yj_q <= yi_q;
      end
      default: ;
    endcase
    if (wr_req) begin
      out_query_q <= ReqWrite;
      out_hit_q   <= 1'b0;
      out_cell_q  <= '0;
    end else if (state_q == StDone && out_free) begin
      out_query_q <= ReqQuery;
      out_hit_q   <= !cell_over;
      out_cell_q  <= cell_over ? '0 : k_q[CellW-1:0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_query_q;
  assign m_axis_tdata_o  = {{(OutDataW - CellW - 1){1'b0}}, out_cell_q, out_hit_q};

  // Checks
  `PIP_ASSERT_NEXT(a_wr_ack, wr_req, m_axis_tvalid_o && (m_axis_tuser_o == ReqWrite) && (m_axis_tdata_o == '0), "write request without clean acknowledge")
  `PIP_ASSERT(a_edge_idx, state_q == StCmp, i_q < n_q, "edge index beyond vertex count")
  `PIP_ASSERT(a_cell_lim, state_q == StFetch, (k_q < limit_q) && (n_q != '0), "edge walk outside examined polygons")
  `PIP_ASSERT_NEXT(a_busy, s_acc && (s_axis_tuser_i == ReqQuery), !s_axis_tready_o, "query not holding off requests")

endmodule

>>> tb/sv/point_in_polygon_hit_test_unit_checker.sv
// Checker for the hit test unit: tracks the polygon store, predicts each answer, compares.
module point_in_polygon_hit_test_unit_checker
  import pip_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  input  logic                s_axis_tready_i,
  // cell_index, vertex_index, vertex_x, vertex_y, point_x, point_y, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // req_type
  input  logic                s_axis_tuser_i,
  // last_vertex
  input  logic                s_axis_tlast_i,
  input  logic                m_axis_tvalid_i,
  input  logic                m_axis_tready_i,
  // hit, hit_cell, zero pad
  input  logic [OutDataW-1:0] m_axis_tdata_i,
  // is_query
  input  logic                m_axis_tuser_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  output int                  pending_o,
  output int                  fail_count_o
);

  typedef struct packed {
    logic             is_query;
    logic             hit;
    logic [CellW-1:0] hit_cell;
  } answer_t;

  // Shadow copy of the polygon store and the cell_count register
  logic signed [CoordW-1:0] vx_mem     [Depth];
  logic signed [CoordW-1:0] vy_mem     [Depth];
  logic [CntW-1:0]          vert_count [MaxCells];
  logic [CfgW-1:0]          cell_limit;

  // Answers owed by the block, oldest first
  answer_t answer_q [$];

  answer_t                  got_answer;
  answer_t                  want_answer;
  answer_t                  owed_answer;
  int                       wr_addr;
  logic [CellW-1:0]         wr_poly;
  logic [VertW-1:0]         wr_vert;

  // Crossing-number parity for one stored polygon, exact and division free
  function automatic logic polygon_encloses(int poly, longint px, longint py);
    int     n;
    int     j;
    int     base;
    longint xi, yi, xj, yj, d, lhs, rhs;
    logic   odd;
    logic   right;
    n    = vert_count[poly];
    base = poly * MaxVerts;
    odd  = 1'b0;
    if (n == 0) return 1'b0;
    if (n > MaxVerts) n = MaxVerts;
    j = n - 1;
    for (int i = 0; i < n; i++) begin
      xi = vx_mem[base + i];
      yi = vy_mem[base + i];
      xj = vx_mem[base + j];
      yj = vy_mem[base + j];
      if ((yi <= py && py < yj) || (yj <= py && py < yi)) begin
        d     = yj - yi;
        lhs   = (px - xi) * d;
        rhs   = (xj - xi) * (py - yi);
        right = (d > 0) ? (lhs > rhs) : (lhs < rhs);
        if (right) odd = !odd;
      end
      j = i;
    end
    return odd;
  endfunction

  // First polygon among the examined ones that holds the point
  function automatic answer_t first_hit(logic signed [CoordW-1:0] qx,
                                        logic signed [CoordW-1:0] qy);
    answer_t ans;
    int      limit;
    longint  px, py;
    ans   = '{is_query: 1'b1, hit: 1'b0, hit_cell: '0};
    px    = qx;
    py    = qy;
    limit = (cell_limit > MaxCells) ? MaxCells : cell_limit;
    for (int k = 0; k < limit; k++) begin
      if (polygon_encloses(k, px, py)) begin
        ans.hit      = 1'b1;
        ans.hit_cell = k[CellW-1:0];
        return ans;
      end
    end
    return ans;
  endfunction

  task automatic note_mismatch(string what, int want, int got);
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < MaxCells; c++) vert_count[c] = '0;
      cell_limit = '0;
      answer_q.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      // Result side: compare against the oldest owed answer
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got_answer = '{is_query: m_axis_tuser_i, hit: m_axis_tdata_i[0],
                       hit_cell: m_axis_tdata_i[1 +: CellW]};
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %0h",
                   $time, got_answer);
          fail_count_o++;
        end else begin
          want_answer = answer_q.pop_front();
          if (got_answer.is_query !== want_answer.is_query)
            note_mismatch("is_query", want_answer.is_query, got_answer.is_query);
          if (got_answer.hit !== want_answer.hit)
            note_mismatch("hit", want_answer.hit, got_answer.hit);
          if (got_answer.hit_cell !== want_answer.hit_cell)
            note_mismatch("hit_cell", want_answer.hit_cell, got_answer.hit_cell);
        end
      end

      // Register write
      if (cfg_valid_i && cfg_ready_i) cell_limit = cfg_data_i;

      // Request side: update the store or predict the query answer
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (s_axis_tuser_i == ReqWrite) begin
          wr_poly = s_axis_tdata_i[OffCell +: CellW];
          wr_vert = s_axis_tdata_i[OffVert +: VertW];
          wr_addr = wr_poly * MaxVerts + wr_vert;
          vx_mem[wr_addr] = s_axis_tdata_i[OffVx +: CoordW];
          vy_mem[wr_addr] = s_axis_tdata_i[OffVy +: CoordW];
          if (s_axis_tlast_i) vert_count[wr_poly] = CntW'(wr_vert) + CntW'(1);
          owed_answer = '{is_query: 1'b0, hit: 1'b0, hit_cell: '0};
        end else begin
          owed_answer = first_hit(s_axis_tdata_i[OffPx +: CoordW],
                                  s_axis_tdata_i[OffPy +: CoordW]);
        end
        answer_q.insert(answer_q.size(), owed_answer);
      end

      pending_o <= answer_q.size();
    end
  end

endmodule

>>> tb/sv/point_in_polygon_hit_test_unit_tb.sv
// Testbench top for the hit test unit: clock, reset, request and config stimulus, verdict.
module point_in_polygon_hit_test_unit_tb;
  import pip_pkg::*;

  localparam int TotalItems = 1050;
  localparam int CycleLimit = 12_000_000;

  logic                clk_i;
  logic                rst_ni    = 1'b0;
  logic                s_tvalid  = 1'b0;
  logic                s_tuser   = 1'b0;
  logic                s_tlast   = 1'b0;
  logic [InDataW-1:0]  s_tdata   = '0;
  logic                m_tready  = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [CfgW-1:0]     cfg_data  = '0;

  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tuser_o;
  logic                cfg_ready_o;

  int pending;
  int fail_count;
  int cycle_count = 0;
  int items_sent  = 0;

  // Idling modes, redrawn per phase
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int rx_hold    = 0;
  int rx_draw;

  // Vertices written so far per polygon; a close is only sent over written vertices
  int vertex_written [MaxCells];

  point_in_polygon_hit_test_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data)
  );

  point_in_polygon_hit_test_unit_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_data_i      (cfg_data),
    .pending_o       (pending),
    .fail_count_o    (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Timeout guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("** point_in_polygon_hit_test_unit: FAILED **");
      $finish;
    end
  end

  // Result receiver: random stall after each result while idling is on
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
      rx_hold  <= 0;
    end else if (m_axis_tvalid_o && m_tready) begin
      rx_draw = rx_idle_on ? $urandom_range(0, 3) : 0;
      m_tready <= (rx_draw == 0);
      rx_hold  <= (rx_draw > 0) ? rx_draw - 1 : 0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // One request on the slave channel, after a random gap
  task automatic send_item(logic kind, logic close, logic [InDataW-1:0] payload);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tlast  <= close;
    s_tdata  <= payload;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
  endtask

  task automatic send_write(int poly, int vert, int x, int y, bit close);
    logic [InDataW-1:0] payload;
    int                 lowmask;
    bit                 closes;
    lowmask = (1 << (vert + 1)) - 1;
    closes  = close && (((vertex_written[poly] | (1 << vert)) & lowmask) == lowmask);
    vertex_written[poly] |= (1 << vert);
    payload = '0;
    payload[OffCell +: CellW] = CellW'(poly);
    payload[OffVert +: VertW] = VertW'(vert);
    payload[OffVx +: CoordW]  = CoordW'(x);
    payload[OffVy +: CoordW]  = CoordW'(y);
    payload[OffPx +: CoordW]  = CoordW'($urandom);
    payload[OffPy +: CoordW]  = CoordW'($urandom);
    send_item(ReqWrite, closes, payload);
  endtask

  task automatic send_query(int x, int y);
    logic [InDataW-1:0] payload;
    payload = '0;
    payload[OffCell +: CellW] = CellW'($urandom);
    payload[OffVert +: VertW] = VertW'($urandom);
    payload[OffVx +: CoordW]  = CoordW'($urandom);
    payload[OffVy +: CoordW]  = CoordW'($urandom);
    payload[OffPx +: CoordW]  = CoordW'(x);
    payload[OffPy +: CoordW]  = CoordW'(y);
    send_item(ReqQuery, 1'($urandom_range(0, 1)), payload);
  endtask

  // Hold requests until every owed result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_cell_count(int value);
    cfg_valid <= 1'b1;
    cfg_data  <= CfgW'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
  endtask

  // Span 0 means the full coordinate range
  function automatic int rand_coord(int span);
    if (span == 0) return int'($urandom_range(0, 65535)) - 32768;
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Well-formed polygon: vertices in order, closed on the last one
  task automatic send_polygon(int span);
    int poly;
    int n;
    poly = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MaxCells - 1)
                                       : $urandom_range(0, 7);
    n    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, MaxVerts)
                                       : $urandom_range(3, 6);
    for (int v = 0; v < n; v++)
      send_write(poly, v, rand_coord(span), rand_coord(span), v == n - 1);
  endtask

  initial begin
    int batch_start;
    int span;
    int pick;
    for (int c = 0; c < MaxCells; c++) vertex_written[c] = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: nothing examined while cell_count is zero
    write_cell_count(0);
    send_query(0, 0);
    send_write(0, 0, -100, -100, 1'b0);
    send_write(0, 1,  100, -100, 1'b0);
    send_write(0, 2,  100,  100, 1'b0);
    send_write(0, 3, -100,  100, 1'b1);
    send_query(0, 0);

    // Square: inside, on each side, outside
    drain();
    write_cell_count(MaxCells);
    send_query(0, 0);
    send_query(-100, 0);
    send_query(100, 0);
    send_query(0, -100);
    send_query(0, 100);
    send_query(200, 0);

    // Extreme triangle, single-vertex and two-vertex polygons; cell 4 stays empty
    send_write(1, 0, -32768, -32768, 1'b0);
    send_write(1, 1,  32767, -32768, 1'b0);
    send_write(1, 2, -32768,  32767, 1'b1);
    send_write(2, 0, 5, 5, 1'b1);
    send_write(3, 0, 0, -50, 1'b0);
    send_write(3, 1, 0,  50, 1'b1);
    send_query(32767, 32767);
    send_query(-32768, -32768);
    send_query(1000, 1000);

    // Count above the polygon total saturates; count of one hides cell 1
    drain();
    write_cell_count(63);
    send_query(1000, 1000);
    drain();
    write_cell_count(1);
    send_query(1000, 1000);

    // Random phases
    while (items_sent < TotalItems) begin
      drain();
      case ($urandom_range(0, 5))
        0:       write_cell_count(0);
        1:       write_cell_count(MaxCells);
        2:       write_cell_count(63);
        3:       write_cell_count($urandom_range(1, 8));
        4:       write_cell_count($urandom_range(0, 63));
        default: write_cell_count($urandom_range(MaxCells + 1, 62));
      endcase
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0:       span = 16;
        1:       span = 200;
        2:       span = 4000;
        default: span = 0;
      endcase
      batch_start = items_sent;
      while (items_sent - batch_start < 60 && items_sent < TotalItems) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          send_polygon(span);
        end else if (pick < 8) begin
          send_query(rand_coord(span), rand_coord(span));
        end else begin
          // Stray vertex, sometimes closing a polygon early
          send_write($urandom_range(0, MaxCells - 1), $urandom_range(0, MaxVerts - 1),
                     rand_coord(span), rand_coord(span), $urandom_range(0, 3) == 0);
        end
        if ($urandom_range(0, 39) == 0) drain();
      end
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** point_in_polygon_hit_test_unit: PASSED **");
    end else begin
      $display("** point_in_polygon_hit_test_unit: FAILED **");
    end
    $finish;
  end

endmodule
